// ===== src/bit_parallel_edit_distance_macros.svh =====
// assertion helpers for the edit distance rtl
`ifndef BIT_PARALLEL_EDIT_DISTANCE_MACROS_SVH
`define BIT_PARALLEL_EDIT_DISTANCE_MACROS_SVH

// same-cycle implication, reset masks the check
`define BPED_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define BPED_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bped_pkg.sv =====
package bped_pkg;

	// default sizes
	localparam int DEF_WORD_BITS     = 64;
	localparam int DEF_ALPHABET_SIZE = 256;

	// fixed field widths
	localparam int SYM_W       = 8;
	localparam int MASK_PORT_W = 64;
	localparam int DIST_W      = 16;
	localparam int PLEN_W      = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int TDATA_IN_W  = SYM_W + MASK_PORT_W;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// request kinds carried on tuser
	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_TEXT   = 2'd1,
		REQ_FINISH = 2'd2
	} req_type_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRANSPOSITION = 2'd0,
		CFG_PATTERN_LEN   = 2'd1,
		CFG_CHECK_MASK    = 2'd2,
		CFG_INIT_VERT     = 2'd3
	} cfg_reg_t;

endpackage

// ===== src/bped_step.sv =====
module bped_step
	import bped_pkg::*;
#(
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                 trans_on,
	input  logic [WORD_BITS-1:0] pm,
	input  logic [WORD_BITS-1:0] prev_pm,
	input  logic [WORD_BITS-1:0] vp,
	input  logic [WORD_BITS-1:0] vn,
	input  logic [WORD_BITS-1:0] d0_prev,
	input  logic [WORD_BITS-1:0] chk,
	input  logic [DIST_W-1:0]    dist_cur,
	output logic [WORD_BITS-1:0] vp_nx,
	output logic [WORD_BITS-1:0] vn_nx,
	output logic [WORD_BITS-1:0] d0,
	output logic [DIST_W-1:0]    dist_nx
);

	logic [WORD_BITS-1:0] tr;
	logic [WORD_BITS-1:0] sum;
	logic [WORD_BITS-1:0] hp;
	logic [WORD_BITS-1:0] hn;
	logic [WORD_BITS-1:0] hps;
	logic                 up;
	logic                 dn;

	// transposition term from the previous column
	assign tr = trans_on ? ((((~d0_prev) & pm) << 1) & prev_pm) : '0;

	// diagonal zero vector, one carry chain
	assign sum = (pm & vp) + vp;
	assign d0  = (sum ^ vp) | pm | vn | tr;

	// horizontal deltas
	assign hp = vn | ~(d0 | vp);
	assign hn = d0 & vp;

	// score change at the last pattern position
	assign up = |(hp & chk);
	assign dn = |(hn & chk);

	always_comb begin
		dist_nx = dist_cur;
		if (up) begin
			if (dist_cur != DIST_MAX) dist_nx = dist_cur + DIST_W'(1);
		end else if (dn) begin
			if (dist_cur != '0) dist_nx = dist_cur - DIST_W'(1);
		end
	end

	// new vertical deltas
	assign hps   = {hp[WORD_BITS-2:0], 1'b1};
	assign vp_nx = {hn[WORD_BITS-2:0], 1'b0} | ~(d0 | hps);
	assign vn_nx = d0 & hps;

endmodule

// ===== src/bit_parallel_edit_distance.sv =====
// channel   dir  handshake            payload (lowest bit up)
// s_*       in   s_tvalid / s_tready  tdata: symbol[7:0], mask_word[71:8]; tuser: req_type
// m_*       out  m_tvalid / m_tready  tdata: distance[15:0]
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// one request per cycle while the input is not stalled; a text symbol reads its
// match mask from the table in the accept cycle and the update of the delta
// vectors runs off that registered read, so the next symbol can follow directly.
// a finish passes the stage one register, held there behind an untaken result, into the result register.
// reset needs no clearing pass; table entries are undefined until loaded.
// the input stalls only while a finish waits behind an untaken result.
`include "bit_parallel_edit_distance_macros.svh"

module bit_parallel_edit_distance
	import bped_pkg::*;
#(
	parameter int WORD_BITS     = DEF_WORD_BITS,
	parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_IN_W-1:0] s_tdata,  // symbol, mask_word
	input  logic [1:0]            s_tuser,  // req_type
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DIST_W-1:0]     m_tdata,  // distance
	// register writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(ALPHABET_SIZE);
	localparam int CMP_W  = 18;

	// register file
	logic                 trans_on_q;
	logic [PLEN_W-1:0]    plen_q;
	logic [WORD_BITS-1:0] chk_q;
	logic [WORD_BITS-1:0] init_vp_q;
	logic                 rearm_q;

	// text state
	logic [WORD_BITS-1:0] vp_q;
	logic [WORD_BITS-1:0] vn_q;
	logic [WORD_BITS-1:0] d0_q;
	logic [WORD_BITS-1:0] prev_pm_q;
	logic [DIST_W-1:0]    dist_q;

	// stage one
	logic                 valid_s1;
	req_type_t            kind_s1;
	logic                 oor_s1;
	logic [WORD_BITS-1:0] rdata_s1;

	// output register
	logic                 m_valid_q;
	logic [DIST_W-1:0]    m_data_q;

	// match mask table
	logic [WORD_BITS-1:0] mask_mem [ALPHABET_SIZE];

	logic                 accept;
	req_type_t            in_kind;
	logic [SYM_W-1:0]     in_sym;
	logic [CMP_W-1:0]     sym_ext;
	logic                 sym_ok;
	logic [ADDR_W-1:0]    addr;
	logic                 s1_go;
	logic                 fin_go;
	logic                 text_go;
	logic [WORD_BITS-1:0] pm;
	logic [WORD_BITS-1:0] vp_nx;
	logic [WORD_BITS-1:0] vn_nx;
	logic [WORD_BITS-1:0] d0_nx;
	logic [DIST_W-1:0]    dist_nx;

	// request decode
	assign in_kind = req_type_t'(s_tuser);
	assign in_sym  = s_tdata[SYM_W-1:0];
	assign sym_ext = CMP_W'(in_sym);
	assign sym_ok  = sym_ext < CMP_W'(ALPHABET_SIZE);
	assign addr    = sym_ext[ADDR_W-1:0];
	assign accept  = s_tvalid && s_tready;

	// flow control: only a finish behind an untaken result holds stage one
	assign s1_go    = valid_s1 && !(kind_s1 == REQ_FINISH && m_valid_q && !m_tready);
	assign s_tready = !valid_s1 || s1_go;
	assign fin_go   = s1_go && kind_s1 == REQ_FINISH;
	assign text_go  = s1_go && kind_s1 == REQ_TEXT;

	// table write on load, registered read on text
	always_ff @(posedge clk) begin
		if (accept && in_kind == REQ_LOAD && sym_ok) begin
			mask_mem[addr] <= s_tdata[SYM_W +: WORD_BITS];
		end
		if (accept && in_kind == REQ_TEXT) begin
			rdata_s1 <= mask_mem[addr];
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= in_kind;
			oor_s1  <= !sym_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= accept;
		end
	end

	// register writes, each one re-arms the text state next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_on_q <= 1'b0;
			plen_q     <= '0;
			chk_q      <= '0;
			init_vp_q  <= '1;
			rearm_q    <= 1'b0;
		end else begin
			rearm_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_TRANSPOSITION: trans_on_q <= cfg_data[0];
					CFG_PATTERN_LEN:   plen_q     <= cfg_data[PLEN_W-1:0];
					CFG_CHECK_MASK:    chk_q      <= cfg_data[WORD_BITS-1:0];
					CFG_INIT_VERT:     init_vp_q  <= cfg_data[WORD_BITS-1:0];
				endcase
			end
		end
	end

	// column update
	assign pm = oor_s1 ? '0 : rdata_s1;

	bped_step #(
		.WORD_BITS (WORD_BITS)
	) u_step (
		.trans_on (trans_on_q),
		.pm       (pm),
		.prev_pm  (prev_pm_q),
		.vp       (vp_q),
		.vn       (vn_q),
		.d0_prev  (d0_q),
		.chk      (chk_q),
		.dist_cur (dist_q),
		.vp_nx    (vp_nx),
		.vn_nx    (vn_nx),
		.d0       (d0_nx),
		.dist_nx  (dist_nx)
	);

	// text state: re-arm on finish or register write, else advance on text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q      <= '1;
			vn_q      <= '0;
			d0_q      <= '0;
			prev_pm_q <= '0;
			dist_q    <= '0;
		end else begin
			priority if (fin_go || rearm_q) begin
				vp_q      <= init_vp_q;
				vn_q      <= '0;
				d0_q      <= '0;
				prev_pm_q <= '0;
				dist_q    <= DIST_W'(plen_q);
			end else if (text_go) begin
				vp_q      <= vp_nx;
				vn_q      <= vn_nx;
				d0_q      <= d0_nx;
				prev_pm_q <= pm;
				dist_q    <= dist_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fin_go) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			m_data_q <= dist_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// checks
	`BPED_ASSERT_IMP(a_stall_cause, clk, arst_n, !s_tready, valid_s1 && kind_s1 == REQ_FINISH && m_valid_q && !m_tready, "input stalled without a blocked finish")
	`BPED_ASSERT_NXT(a_finish_result, clk, arst_n, fin_go, m_valid_q, "finish left stage one without a result")
	`BPED_ASSERT_NXT(a_finish_rearm, clk, arst_n, fin_go && !cfg_we, dist_q == DIST_W'(plen_q) && vn_q == '0, "text state not re-armed after finish")
	`BPED_ASSERT_IMP(a_delta_disjoint, clk, arst_n, 1'b1, (vp_q & vn_q) == '0, "positive and negative vertical deltas overlap")

endmodule

// ===== bench/edit_distance_checker.sv =====
`timescale 1ns / 1ps

module edit_distance_checker
	import bped_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [TDATA_IN_W-1:0] s_tdata,  // symbol, mask_word
	input  logic [1:0]            s_tuser,  // req_type
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [DIST_W-1:0]     m_tdata,  // distance
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int MISMATCH_REPORTS = 10;

	// register copies
	logic              swap_on;
	logic [PLEN_W-1:0] pat_len;
	logic [63:0]       last_pos;
	logic [63:0]       vp_init;

	// text state
	logic [63:0]       match_tab [DEF_ALPHABET_SIZE];
	logic [63:0]       vp;
	logic [63:0]       vn;
	logic [63:0]       d0_prev;
	logic [63:0]       pm_prev;
	logic [DIST_W-1:0] cur_dist;

	// distances still owed by the block, oldest first
	logic [DIST_W-1:0] expected_dist [$];
	int                n_fail = 0;
	int                n_pending = 0;

	assign fail_count = n_fail;
	assign pending    = n_pending;

	// start a new text from the configured vector
	function automatic void rearm_text();
		vp       = vp_init;
		vn       = '0;
		d0_prev  = '0;
		pm_prev  = '0;
		cur_dist = DIST_W'(pat_len);
	endfunction

	// one text symbol through the delta vectors
	function automatic void step_text(input logic [SYM_W-1:0] sym);
		logic [63:0] pm;
		logic [63:0] tr;
		logic [63:0] d0;
		logic [63:0] hp;
		logic [63:0] hn;
		logic [63:0] hps;
		pm = match_tab[sym];
		tr = swap_on ? ((((~d0_prev) & pm) << 1) & pm_prev) : '0;
		pm_prev = pm;
		d0 = (((pm & vp) + vp) ^ vp) | pm | vn | tr;
		hp = vn | ~(d0 | vp);
		hn = d0 & vp;
		// distance tracked at the last pattern position, saturating both ways
		if ((hp & last_pos) != '0) begin
			if (cur_dist != DIST_MAX) cur_dist = cur_dist + 1'b1;
		end else if ((hn & last_pos) != '0) begin
			if (cur_dist != '0) cur_dist = cur_dist - 1'b1;
		end
		hps     = (hp << 1) | 64'd1;
		vp      = (hn << 1) | ~(d0 | hps);
		vn      = d0 & hps;
		d0_prev = d0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_on  = 1'b0;
			pat_len  = '0;
			last_pos = '0;
			vp_init  = '1;
			rearm_text();
			expected_dist.delete();
			n_pending = 0;
		end else begin
			// any register write re-arms the text
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_TRANSPOSITION: swap_on  = cfg_data[0];
					CFG_PATTERN_LEN:   pat_len  = cfg_data[PLEN_W-1:0];
					CFG_CHECK_MASK:    last_pos = cfg_data;
					CFG_INIT_VERT:     vp_init  = cfg_data;
					default: ;
				endcase
				rearm_text();
			end
			// accepted request
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					REQ_LOAD:   match_tab[s_tdata[SYM_W-1:0]] = s_tdata[TDATA_IN_W-1:SYM_W];
					REQ_TEXT:   step_text(s_tdata[SYM_W-1:0]);
					REQ_FINISH: begin
						expected_dist = {expected_dist, cur_dist};
						rearm_text();
					end
					default: ;
				endcase
			end
			// accepted result against the oldest expected distance
			if (m_tvalid && m_tready) begin
				if (expected_dist.size() == 0) begin
					n_fail++;
					if (n_fail <= MISMATCH_REPORTS)
						$display("%0t: unexpected result, distance %0d", $time, m_tdata);
				end else begin
					if (m_tdata !== expected_dist[0]) begin
						n_fail++;
						if (n_fail <= MISMATCH_REPORTS)
							$display("%0t: distance mismatch, expected %0d, got %0d",
								$time, expected_dist[0], m_tdata);
					end
					void'(expected_dist.pop_front());
				end
			end
			n_pending = expected_dist.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import bped_pkg::*;

	localparam int               CLK_HALF      = 10;
	localparam int               RESET_CYCLES  = 12;
	localparam int               RANDOM_ITEMS  = 1600;
	localparam int               HOLD_CYCLES   = 300;
	localparam int               SETTLE_CYCLES = 4;
	localparam int               CYCLE_LIMIT   = 100000;
	localparam logic [1:0]       REQ_UNUSED    = 2'd3;
	localparam logic [63:0]      ALL_ONES      = {64{1'b1}};
	localparam logic [SYM_W-1:0] SYM_A         = 8'h41;
	localparam logic [SYM_W-1:0] SYM_B         = 8'h42;
	localparam logic [SYM_W-1:0] SYM_C         = 8'h43;
	localparam logic [SYM_W-1:0] SYM_LOW       = 8'h00;
	localparam logic [SYM_W-1:0] SYM_HIGH      = 8'hFF;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [TDATA_IN_W-1:0] s_tdata;  // symbol, mask_word
	logic [1:0]            s_tuser;  // req_type
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DIST_W-1:0]     m_tdata;  // distance
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int  fail_count;
	int  pending;
	int  cycle_count = 0;
	int  items_sent = 0;
	bit  idle_on;
	bit  rx_hold_req;

	// table entries written so far, and the current pattern
	bit               loaded [DEF_ALPHABET_SIZE];
	logic [SYM_W-1:0] loaded_syms [$];
	logic [SYM_W-1:0] alpha [$];
	logic [SYM_W-1:0] pat [64];
	int               pat_len;

	bit_parallel_edit_distance i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	edit_distance_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on demand
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// mostly pattern symbols, sometimes any loaded entry
	function automatic logic [SYM_W-1:0] pick_sym();
		if ($urandom_range(0, 4) == 0)
			return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
		return alpha[$urandom_range(0, alpha.size() - 1)];
	endfunction

	// offer one request, with an optional idle burst first
	task automatic send_req(input logic [1:0] kind, input logic [SYM_W-1:0] sym,
			input logic [63:0] word);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {word, sym};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (kind == REQ_LOAD && !loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_syms = {loaded_syms, sym};
		end
	endtask

	// stop offering until every distance is back and the block settles
	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all four registers on consecutive cycles
	task automatic program_regs(input logic swap, input int len, input logic [63:0] chk,
			input logic [63:0] vinit);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TRANSPOSITION;
		cfg_data  <= 64'(swap);
		@(posedge clk);
		cfg_index <= CFG_PATTERN_LEN;
		cfg_data  <= 64'(len);
		@(posedge clk);
		cfg_index <= CFG_CHECK_MASK;
		cfg_data  <= chk;
		@(posedge clk);
		cfg_index <= CFG_INIT_VERT;
		cfg_data  <= vinit;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// random pattern over a few symbols, masks loaded into the table
	task automatic load_pattern(input int len, input int n_sym);
		logic [63:0] word;
		alpha.delete();
		repeat (n_sym) alpha = {alpha, 8'($urandom_range(0, 255))};
		pat_len = len;
		for (int i = 0; i < len; i++) pat[i] = alpha[$urandom_range(0, n_sym - 1)];
		foreach (alpha[j]) begin
			word = '0;
			for (int i = 0; i < len; i++)
				if (pat[i] == alpha[j]) word[i] = 1'b1;
			send_req(REQ_LOAD, alpha[j], word);
		end
	endtask

	// the pattern with a few edits, or a short random text
	task automatic send_text(input bit with_finish);
		logic [SYM_W-1:0] txt [$];
		logic [SYM_W-1:0] tmp;
		int               pos;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(0, 16)) txt = {txt, pick_sym()};
		end else begin
			for (int i = 0; i < pat_len; i++) txt = {txt, pat[i]};
			repeat ($urandom_range(0, 3)) begin
				pos = (txt.size() == 0) ? 0 : $urandom_range(0, txt.size() - 1);
				case ($urandom_range(0, 3))
					0: if (txt.size() != 0) txt[pos] = pick_sym();
					1: if (txt.size() != 0) txt.delete(pos);
					2: txt.insert(pos, pick_sym());
					default: if (pos + 1 < txt.size()) begin
						tmp          = txt[pos];
						txt[pos]     = txt[pos + 1];
						txt[pos + 1] = tmp;
					end
				endcase
			end
		end
		foreach (txt[i]) send_req(REQ_TEXT, txt[i], rand_word());
		if (with_finish) send_req(REQ_FINISH, 8'($urandom), rand_word());
	endtask

	// stimulus and verdict
	initial begin
		int phase;
		int phase_end;
		int len;
		logic [63:0] chk;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_LOAD;
		cfg_we    = 1'b0;
		cfg_index = CFG_TRANSPOSITION;
		cfg_data  = '0;
		idle_on   = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pattern ABCA with transposition, table extremes, empty text, unused kind
		program_regs(1'b1, 4, 64'd1 << 3, ALL_ONES);
		send_req(REQ_LOAD, SYM_LOW, '0);
		send_req(REQ_LOAD, SYM_HIGH, ALL_ONES);
		send_req(REQ_LOAD, SYM_A, 64'h9);
		send_req(REQ_LOAD, SYM_B, 64'h2);
		send_req(REQ_LOAD, SYM_C, 64'h4);
		send_req(REQ_TEXT, SYM_B, '0);
		send_req(REQ_TEXT, SYM_A, ALL_ONES);
		send_req(REQ_TEXT, SYM_C, '0);
		send_req(REQ_TEXT, SYM_A, ALL_ONES);
		send_req(REQ_FINISH, SYM_HIGH, ALL_ONES);
		send_req(REQ_TEXT, SYM_HIGH, '0);
		send_req(REQ_TEXT, SYM_LOW, '0);
		send_req(REQ_FINISH, SYM_LOW, '0);
		send_req(REQ_FINISH, SYM_A, '0);
		send_req(REQ_UNUSED, SYM_HIGH, ALL_ONES);
		// text left open, abandoned by the next register write
		send_req(REQ_TEXT, SYM_A, '0);
		send_req(REQ_TEXT, SYM_B, '0);
		wait_results();

		// zero length: a match at the checked position floors the distance
		program_regs(1'b0, 0, 64'd1, ALL_ONES);
		send_req(REQ_TEXT, SYM_A, '0);
		send_req(REQ_TEXT, SYM_LOW, '0);
		send_req(REQ_TEXT, SYM_HIGH, '0);
		send_req(REQ_FINISH, SYM_LOW, '0);
		send_req(REQ_FINISH, SYM_HIGH, '0);
		wait_results();

		// full length, every position checked, zero starting vector
		program_regs(1'b1, 64, ALL_ONES, '0);
		send_req(REQ_TEXT, SYM_A, '0);
		send_req(REQ_TEXT, SYM_B, '0);
		send_req(REQ_FINISH, SYM_C, '0);

		// random phases, each with its own setting and pattern
		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			wait_results();
			idle_on = (items_sent < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 4) != 0);
			len = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 12);
			case ($urandom_range(0, 3))
				0: begin
					case ($urandom_range(0, 2))
						0: chk = '0;
						1: chk = ALL_ONES;
						default: chk = rand_word();
					endcase
					program_regs(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 0 : 64,
						chk, $urandom_range(0, 1) ? rand_word() : '0);
				end
				1: program_regs(1'($urandom_range(0, 1)), len, 64'd1 << (len - 1),
					ALL_ONES >> (64 - len));
				default: program_regs(1'($urandom_range(0, 1)), len, 64'd1 << (len - 1),
					ALL_ONES);
			endcase
			load_pattern(len, $urandom_range(2, 6));
			// sender waits for every distance after the first text of the phase
			send_text(1'b1);
			wait_results();
			// long result hold-off while requests keep coming
			if (phase == 2) rx_hold_req = 1'b1;
			phase_end = items_sent + $urandom_range(150, 250);
			while (items_sent < phase_end) begin
				case ($urandom_range(0, 19))
					0: send_req(REQ_LOAD, 8'($urandom), rand_word());
					1: send_req(REQ_UNUSED, 8'($urandom), rand_word());
					2: send_req(REQ_FINISH, 8'($urandom), rand_word());
					3: send_text(1'b0);
					default: send_text(1'b1);
				endcase
				if ($urandom_range(0, 39) == 0) wait_results();
			end
			phase++;
		end

		wait_results();

		if (fail_count == 0 && pending == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
